@@ hw/rtl/fpna_pkg.sv @@
// Shared types and constants for the fixed pool node allocator.
// Depends on nothing; used by the allocator unit and its checker.
package fpna_pkg;

  localparam int NODES_DEFAULT = 64;
  localparam int SLOT_W        = 6;
  localparam int COUNT_W       = 7;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot_in;
  } in_t;

  typedef struct packed {
    logic               status;
    logic [SLOT_W-1:0]  slot_out;
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] used_count;
  } out_t;

endpackage

@@ hw/rtl/fixed_pool_node_allocator_unit.sv @@
// Fixed pool node allocator: free and used slot rings kept in two link memories.
// Depends on fpna_pkg for the payload structs, operation codes and defaults.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    fpna_pkg::in_t  (op, slot_in)
//   out      output     out_valid / out_ready  fpna_pkg::out_t (status, slot_out, counts)
//
// A result reaches the output register through these steps: the transfer edge reads the
// moved slot's links, then three rewrite steps follow, set by the single write port of each
// link memory (three entries of each change), so a request is taken only once the last
// one is through. After reset, S_INIT writes the initial ring order into both memories
// while in_ready stays low. A result waiting on out_ready holds the block in its last step;
// the next request is taken at the edge after the result has moved into the output register.
module fixed_pool_node_allocator_unit #(
  parameter int NODES = fpna_pkg::NODES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpna_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output fpna_pkg::out_t out_data
);

  // Index width of a slot, width of a population count, and width of a prev-memory word,
  // which carries the in-use flag of the slot above the prev link.
  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CW = $clog2(NODES + 1);
  localparam int BW = IW + 1;

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_UNLINK = 6'b000100,
    S_PLACE  = 6'b001000,
    S_LINK   = 6'b010000,
    S_HOLD   = 6'b100000
  } state_t;

  // Link memories. next_mem holds the forward link of each slot; prev_mem holds the
  // backward link with the slot's in-use flag in its top bit.
  logic [IW-1:0] next_mem [NODES];
  logic [BW-1:0] prev_mem [NODES];

  state_t         state_r, state_nxt;
  logic [IW-1:0]  init_cnt_r;
  logic           op_r;
  logic [IW-1:0]  x_r;
  logic           err_r;
  logic           ok_r;
  logic           dne_r;
  logic [IW-1:0]  h_r;
  logic [IW-1:0]  after_r;
  logic [IW-1:0]  free_head_r, used_head_r;
  logic [CW-1:0]  free_total_r, used_total_r;
  logic [IW-1:0]  rd_next_r;
  logic [BW-1:0]  rd_prev_r;
  logic           out_valid_r;
  fpna_pkg::out_t out_data_r;

  // Memory port controls.
  logic          we_a, we_b;
  logic [IW-1:0] wa_a, wa_b, ra_a, ra_b;
  logic [IW-1:0] wd_a;
  logic [BW-1:0] wd_b;

  logic          in_fire;
  logic          slot_ok;
  logic [IW-1:0] x_in;
  logic          err_in;
  logic          rel;
  logic [CW-1:0] src_cnt, dst_cnt;
  logic [IW-1:0] dst_head;
  logic          ok_now;
  logic          unlink;
  logic          dne;
  logic          src_flag, dst_flag;
  logic          out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Request decode at the transfer. A release names its slot; an allocate takes the
  // free-ring head. Errors that show without reading the memories are found here.
  assign slot_ok = (32'(in_data.slot_in) < 32'(NODES));
  assign x_in    = (in_data.op == fpna_pkg::OP_RELEASE) ? IW'(in_data.slot_in) : free_head_r;
  always_comb begin
    if (in_data.op == fpna_pkg::OP_ALLOC) begin
      err_in = (free_total_r == '0);
    end else begin
      err_in = (used_total_r == '0) || !slot_ok;
    end
  end

  // The moved slot leaves its source ring and joins the destination ring. Every slot on
  // the free ring has a clear in-use flag and every slot on the used ring a set one, so
  // a rewritten prev word takes the flag of the ring it belongs to.
  assign rel      = (op_r == fpna_pkg::OP_RELEASE);
  assign src_cnt  = rel ? used_total_r : free_total_r;
  assign dst_cnt  = rel ? free_total_r : used_total_r;
  assign dst_head = rel ? free_head_r : used_head_r;
  assign src_flag = rel;
  assign dst_flag = !rel;
  assign ok_now   = !err_r && !(rel && !rd_prev_r[IW]);
  assign unlink   = ok_now && (src_cnt > CW'(1));
  assign dne      = (dst_cnt != '0);

  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    wa_a = x_r;
    wa_b = x_r;
    wd_a = x_r;
    wd_b = {dst_flag, x_r};
    ra_a = x_in;
    ra_b = x_in;
    case (state_r)
      S_INIT: begin
        // Initial ring order: every slot free, linked to its neighbors.
        we_a = 1'b1;
        we_b = 1'b1;
        wa_a = init_cnt_r;
        wa_b = init_cnt_r;
        wd_a = (init_cnt_r == IW'(NODES - 1)) ? '0 : init_cnt_r + IW'(1);
        wd_b = {1'b0, (init_cnt_r == '0) ? IW'(NODES - 1) : init_cnt_r - IW'(1)};
      end
      S_UNLINK: begin
        // Close the gap on the source ring: next[prev] = next, prev[next] = prev.
        // Meanwhile fetch the successor of the destination head.
        we_a = unlink;
        we_b = unlink;
        wa_a = rd_prev_r[IW-1:0];
        wd_a = rd_next_r;
        wa_b = rd_next_r;
        wd_b = {src_flag, rd_prev_r[IW-1:0]};
        ra_a = dst_head;
      end
      S_PLACE: begin
        // Set the moved slot's own links: after the head, or to itself on an empty ring.
        we_a = ok_r;
        we_b = ok_r;
        wa_a = x_r;
        wa_b = x_r;
        wd_a = dne_r ? rd_next_r : x_r;
        wd_b = {dst_flag, dne_r ? h_r : x_r};
      end
      S_LINK: begin
        // Point the head forward and its old successor backward at the moved slot.
        we_a = ok_r && dne_r;
        we_b = ok_r && dne_r;
        wa_a = h_r;
        wd_a = x_r;
        wa_b = after_r;
        wd_b = {dst_flag, x_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      next_mem[wa_a] <= wd_a;
    end
    rd_next_r <= next_mem[ra_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      prev_mem[wa_b] <= wd_b;
    end
    rd_prev_r <= prev_mem[ra_b];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (init_cnt_r == IW'(NODES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_UNLINK;
        end
      end
      S_UNLINK: state_nxt = S_PLACE;
      S_PLACE:  state_nxt = S_LINK;
      S_LINK: begin
        state_nxt = out_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      free_head_r  <= '0;
      used_head_r  <= '0;
      free_total_r <= CW'(NODES);
      used_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) begin
        init_cnt_r <= init_cnt_r + IW'(1);
      end

      if (in_fire) begin
        op_r  <= in_data.op;
        x_r   <= x_in;
        err_r <= err_in;
      end

      if (state_r == S_UNLINK) begin
        ok_r  <= ok_now;
        dne_r <= dne;
        h_r   <= dst_head;
        if (ok_now) begin
          if (!rel) begin
            if (free_total_r > CW'(1)) begin
              free_head_r <= rd_next_r;
            end
            free_total_r <= free_total_r - CW'(1);
            if (used_total_r == '0) begin
              used_head_r <= x_r;
            end
            used_total_r <= used_total_r + CW'(1);
          end else begin
            if ((used_total_r > CW'(1)) && (x_r == used_head_r)) begin
              used_head_r <= rd_next_r;
            end
            used_total_r <= used_total_r - CW'(1);
            if (free_total_r == '0) begin
              free_head_r <= x_r;
            end
            free_total_r <= free_total_r + CW'(1);
          end
        end
      end

      if (state_r == S_PLACE) begin
        after_r <= rd_next_r;
      end

      // The result moves into the output register once the previous one has left.
      if (((state_r == S_LINK) || (state_r == S_HOLD)) && out_free) begin
        out_valid_r           <= 1'b1;
        out_data_r.status     <= ok_r ? fpna_pkg::STATUS_OK : fpna_pkg::STATUS_ERR;
        out_data_r.slot_out   <= (ok_r && !rel) ? fpna_pkg::SLOT_W'(x_r) : '0;
        out_data_r.free_count <= fpna_pkg::COUNT_W'(free_total_r);
        out_data_r.used_count <= fpna_pkg::COUNT_W'(used_total_r);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/fpna_checker.sv @@
// Port-level checker for the fixed pool node allocator, bound to its top level.
// Depends on fpna_pkg for the payload structs.
module fpna_checker #(
  parameter int NODES = fpna_pkg::NODES_DEFAULT
) (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input fpna_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input fpna_pkg::out_t out_data
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One request at a time: after a transfer the block is busy for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in progress");

  // Every slot is either free or used.
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.free_count + out_data.used_count) == fpna_pkg::COUNT_W'(NODES))
    else $error("free and used counts do not cover the pool");

  // Reset clears the output and holds off requests.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("block not quiet after reset");

endmodule

bind fixed_pool_node_allocator_unit fpna_checker #(.NODES(NODES)) u_fpna_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/fixed_pool_node_allocator_unit_test.sv @@
// Self-checking testbench for fixed_pool_node_allocator_unit: a directed table, then random
// allocate/release traffic scored against an in-bench model of the free and used slot rings.
// Depends on fpna_pkg and the allocator RTL only.
module fixed_pool_node_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fpna_pkg::*;

  localparam int POOL_SLOTS   = NODES_DEFAULT;
  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int IDLE_PCT     = 31;
  localparam int DRAIN_CYCLES = 20;

  // Traffic shapes for the random part. Fill and drain push the pool to its
  // two walls (exhausted and nothing in use); mixed wanders in the middle;
  // noise releases arbitrary slot numbers, so most of its releases are rejected.
  typedef enum logic [1:0] {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIXED,
    MODE_NOISE
  } traffic_mode_t;

  // One row of the directed table. When pinned is set, the reply is typed in
  // by hand and replaces the model's answer; otherwise the model decides.
  typedef struct {
    logic  op;
    logic  [SLOT_W-1:0] slot;
    bit    pinned;
    out_t  reply;
  } plan_row_t;

  localparam out_t NO_REPLY = '0;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  // Model of the two rings: one pair of link tables shared by both rings,
  // a per-slot allocated flag, the two heads and the two populations.
  logic [SLOT_W-1:0]  link_next [POOL_SLOTS];
  logic [SLOT_W-1:0]  link_prev [POOL_SLOTS];
  bit                 slot_taken [POOL_SLOTS];
  logic [SLOT_W-1:0]  free_ring_head;
  logic [SLOT_W-1:0]  used_ring_head;
  logic [COUNT_W-1:0] free_slots;
  logic [COUNT_W-1:0] used_slots;

  out_t replies_due[$];
  int   requests_taken;
  int   failures;
  int   cycles;
  bit   calm;
  bit   pinned_now;
  out_t pinned_reply;

  plan_row_t opening_plan [18] = '{
    // Releases while nothing is in use, at both ends of the slot field.
    '{OP_RELEASE, 6'd0,  1'b1, {STATUS_ERR, 6'd0, 7'd64, 7'd0}},
    '{OP_RELEASE, 6'd63, 1'b1, {STATUS_ERR, 6'd0, 7'd64, 7'd0}},
    // The first allocates walk the free ring in order; the slot field is ignored.
    '{OP_ALLOC,   6'd63, 1'b1, {STATUS_OK,  6'd0, 7'd63, 7'd1}},
    '{OP_ALLOC,   6'd0,  1'b1, {STATUS_OK,  6'd1, 7'd62, 7'd2}},
    '{OP_ALLOC,   6'd42, 1'b1, {STATUS_OK,  6'd2, 7'd61, 7'd3}},
    // Releasing a slot that is still free is refused.
    '{OP_RELEASE, 6'd63, 1'b1, {STATUS_ERR, 6'd0, 7'd61, 7'd3}},
    // Slot 0 is the used-ring head, so the head has to move on.
    '{OP_RELEASE, 6'd0,  1'b1, {STATUS_OK,  6'd0, 7'd62, 7'd2}},
    // From here the ring order gets interesting and the model scores each reply.
    '{OP_ALLOC,   6'd21, 1'b0, NO_REPLY},
    '{OP_ALLOC,   6'd0,  1'b0, NO_REPLY},
    '{OP_RELEASE, 6'd42, 1'b0, NO_REPLY},
    '{OP_RELEASE, 6'd2,  1'b0, NO_REPLY},
    '{OP_RELEASE, 6'd1,  1'b0, NO_REPLY},
    '{OP_RELEASE, 6'd3,  1'b0, NO_REPLY},
    // Last used slot goes back, leaving the used ring empty.
    '{OP_RELEASE, 6'd0,  1'b0, NO_REPLY},
    '{OP_RELEASE, 6'd21, 1'b1, {STATUS_ERR, 6'd0, 7'd64, 7'd0}},
    '{OP_ALLOC,   6'd21, 1'b0, NO_REPLY},
    '{OP_ALLOC,   6'd63, 1'b0, NO_REPLY},
    '{OP_RELEASE, 6'd21, 1'b0, NO_REPLY}
  };

  fixed_pool_node_allocator_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Prints one line per mismatch and keeps the tally used by the final verdict.
  task automatic note_failure(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    failures++;
  endtask

  // Splices a slot out of whichever ring holds it.
  function automatic void unlink_slot(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    p = link_prev[s];
    n = link_next[s];
    link_next[p] = n;
    link_prev[n] = p;
  endfunction

  // Threads slot s into a ring directly behind the given head.
  function automatic void insert_after(input logic [SLOT_W-1:0] head,
                                       input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] after;
    after = link_next[head];
    link_prev[s]     = head;
    link_next[s]     = after;
    link_prev[after] = s;
    link_next[head]  = s;
  endfunction

  function automatic void reset_rings();
    for (int i = 0; i < POOL_SLOTS; i++) begin
      link_next[i]  = SLOT_W'((i + 1) % POOL_SLOTS);
      link_prev[i]  = SLOT_W'((i + POOL_SLOTS - 1) % POOL_SLOTS);
      slot_taken[i] = 1'b0;
    end
    free_ring_head = '0;
    used_ring_head = '0;
    free_slots     = COUNT_W'(POOL_SLOTS);
    used_slots     = '0;
  endfunction

  // Applies one accepted request to the ring model and returns the reply the
  // block owes for it. Rejected requests leave every piece of state alone.
  function automatic out_t apply_request(input in_t req);
    out_t              rsp;
    logic [SLOT_W-1:0] s;
    logic [SLOT_W-1:0] n;
    rsp = '0;
    if (req.op == OP_ALLOC) begin
      if (free_slots == 0) begin
        rsp.status = STATUS_ERR;
      end else begin
        s = free_ring_head;
        // Taking the last free slot leaves the free head pointing at it.
        if (free_slots > 1) begin
          n = link_next[s];
          unlink_slot(s);
          free_ring_head = n;
        end
        free_slots--;
        if (used_slots == 0) begin
          used_ring_head = s;
          link_next[s]   = s;
          link_prev[s]   = s;
        end else begin
          insert_after(used_ring_head, s);
        end
        used_slots++;
        slot_taken[s] = 1'b1;
        rsp.slot_out  = s;
      end
    end else begin
      s = req.slot_in;
      if (used_slots == 0 || !slot_taken[s]) begin
        rsp.status = STATUS_ERR;
      end else begin
        if (used_slots > 1) begin
          n = link_next[s];
          unlink_slot(s);
          if (s == used_ring_head) used_ring_head = n;
        end
        used_slots--;
        if (free_slots == 0) begin
          free_ring_head = s;
          link_next[s]   = s;
          link_prev[s]   = s;
        end else begin
          insert_after(free_ring_head, s);
        end
        free_slots++;
        slot_taken[s] = 1'b0;
      end
    end
    rsp.free_count = free_slots;
    rsp.used_count = used_slots;
    return rsp;
  endfunction

  // Picks the next random request from the current model state, so that most
  // releases name a slot that really is allocated.
  function automatic in_t choose_request(input traffic_mode_t mode);
    in_t req;
    int  alloc_pct;
    int  start;
    req.slot_in = SLOT_W'($urandom_range(0, POOL_SLOTS - 1));
    case (mode)
      MODE_FILL:  alloc_pct = 88;
      MODE_DRAIN: alloc_pct = 12;
      default:    alloc_pct = 50;
    endcase
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.op = OP_ALLOC;
    end else begin
      req.op = OP_RELEASE;
      if (mode != MODE_NOISE && used_slots != 0 && $urandom_range(0, 99) < 92) begin
        start = $urandom_range(0, POOL_SLOTS - 1);
        for (int k = 0; k < POOL_SLOTS; k++) begin
          if (slot_taken[(start + k) % POOL_SLOTS]) begin
            req.slot_in = SLOT_W'((start + k) % POOL_SLOTS);
            break;
          end
        end
      end
    end
    return req;
  endfunction

  // Offers one request at the falling edge and holds it until the transfer.
  // Idle cycles in front of it drop valid; valid is never dropped while an
  // item is on offer. Returns at the falling edge after the transfer, so the
  // caller may put the next item on the bus in that same step.
  task automatic send_request(input in_t req, input bit pinned, input out_t reply);
    int seen;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= req;
    pinned_now   <= pinned;
    pinned_reply <= reply;
    seen = requests_taken;
    do @(negedge clk); while (requests_taken == seen);
  endtask

  // Port watcher: every request transfer advances the model and queues its
  // reply; every result transfer is checked against the oldest queued reply.
  always @(posedge clk) begin : watch_ports
    out_t want;
    out_t got;
    if (rst_n && in_valid && in_ready) begin
      want = apply_request(in_data);
      replies_due.push_back(pinned_now ? pinned_reply : want);
      requests_taken++;
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (replies_due.size() == 0) begin
        note_failure($sformatf("result with nothing pending: %p", got));
      end else begin
        want = replies_due.pop_front();
        if (got.status !== want.status)
          note_failure($sformatf("status %0b, wanted %0b", got.status, want.status));
        if (got.slot_out !== want.slot_out)
          note_failure($sformatf("slot_out %0d, wanted %0d", got.slot_out, want.slot_out));
        if (got.free_count !== want.free_count)
          note_failure($sformatf("free_count %0d, wanted %0d",
                                 got.free_count, want.free_count));
        if (got.used_count !== want.used_count)
          note_failure($sformatf("used_count %0d, wanted %0d",
                                 got.used_count, want.used_count));
      end
    end
  end

  // The result side stalls at random, except through the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: a hang anywhere, including the clearing pass after reset, ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    traffic_mode_t mode;
    int            phase_left;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    pinned_now     = 1'b0;
    pinned_reply   = '0;
    calm           = 1'b0;
    requests_taken = 0;
    failures       = 0;
    cycles         = 0;
    phase_left     = 0;
    mode           = MODE_FILL;
    reset_rings();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: the table above, in order.
    foreach (opening_plan[i]) begin
      send_request('{op: opening_plan[i].op, slot_in: opening_plan[i].slot},
                   opening_plan[i].pinned, opening_plan[i].reply);
    end

    // Random part: phases of fill, drain, mixed and noise traffic of random
    // length, so the pool keeps hitting both the exhausted and the empty walls.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (phase_left == 0) begin
        mode       = traffic_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 90);
      end
      calm = (i >= 500 && i < 750);
      // Once, hold the next request back until every reply is in, so the
      // block sees a request arrive while fully quiet.
      if (i == 300) begin
        while (replies_due.size() != 0) begin
          in_valid <= 1'b0;
          @(negedge clk);
        end
      end
      send_request(choose_request(mode), 1'b0, NO_REPLY);
      phase_left--;
    end
    in_valid <= 1'b0;

    // Wait out the replies still in flight, then a few more cycles so that
    // a stray extra result would still be caught.
    while (replies_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
